// File: rtl/lscs_pkg.sv
// Shared types, constants and a helper function for the LRU cache model block.
package lscs_pkg;

    // Field widths
    localparam int ADDR_W       = 64;
    localparam int OP_W         = 2;
    localparam int TOT_W        = 32;
    localparam int SET_BITS_W   = 4;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    localparam logic [TOT_W-1:0] SAT_MAX = '1;

    // Lookup status handed from the tag compare to the control
    typedef struct packed {
        logic hit;
        logic evict;
    } lkup_stat_t;

    // Saturating increment of a running total
    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v, input logic en);
        logic [TOT_W-1:0] r;
        r = v;
        if (en && (v != SAT_MAX))
        begin
            r = v + TOT_W'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/lscs_ifs.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
interface lscs_req_if;
    logic                          valid;
    logic                          ready;
    logic [lscs_pkg::OP_W-1:0]     operation;
    logic [lscs_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface lscs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          was_hit;
    logic                          was_evicted;
    logic                          modify_hit;
    logic [lscs_pkg::TOT_W-1:0]    hits_so_far;
    logic [lscs_pkg::TOT_W-1:0]    misses_so_far;
    logic [lscs_pkg::TOT_W-1:0]    evictions_so_far;

    modport source (output valid, output was_hit, output was_evicted, output modify_hit,
                    output hits_so_far, output misses_so_far, output evictions_so_far,
                    input ready);
    modport sink   (input valid, input was_hit, input was_evicted, input modify_hit,
                    input hits_so_far, input misses_so_far, input evictions_so_far,
                    output ready);
endinterface

interface lscs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lscs_pkg::CFG_IDX_W-1:0]    index;
    logic [lscs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lscs_mem.sv
// Set row memory: one row of tags and fill count per set, with per-row valid flags.
module lscs_mem #(
    parameter int ADDR_BITS = 8,
    parameter int ROW_W     = 516
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [ROW_W-1:0]     rd_data,
    output logic                 rd_ok,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [ROW_W-1:0]     wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [ROW_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] row_ok_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_ok_reg;

    // Write the row and read the row; read data is registered and lands in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Mark rows written since reset; an unmarked row reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_ok_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= row_ok_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_ok   = rd_ok_reg;

endmodule

// File: rtl/lscs_lookup.sv
// Tag compare and LRU reorder of one set row.
module lscs_lookup #(
    parameter int MAX_WAYS = 8
) (
    input  logic [MAX_WAYS-1:0][lscs_pkg::ADDR_W-1:0] row_tags,
    input  logic [$clog2(MAX_WAYS+1)-1:0]             row_fill,
    input  logic                                      row_ok,
    input  logic [lscs_pkg::ADDR_W-1:0]               tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]             num_ways,
    output logic [MAX_WAYS-1:0][lscs_pkg::ADDR_W-1:0] new_tags,
    output logic [$clog2(MAX_WAYS+1)-1:0]             new_fill,
    output lscs_pkg::lkup_stat_t                      stat
);

    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [CNT_W-1:0]                          fill;
    logic [CNT_W-1:0]                          used;
    logic [MAX_WAYS-1:0]                       match;
    logic [WAY_W-1:0]                          hit_idx;
    logic                                      hit;
    logic                                      evict;
    logic [CNT_W-1:0]                          shift_lo;
    logic [CNT_W-1:0]                          last;
    logic [MAX_WAYS-1:0][lscs_pkg::ADDR_W-1:0] up_tags;

    // Clip the fill count to the ways in use
    assign fill = row_ok ? row_fill : '0;
    assign used = (fill > num_ways) ? num_ways : fill;

    // Compare every live way and pick the first match
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            match[i] = (CNT_W'(i) < used) && (row_tags[i] == tag);
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = WAY_W'(i);
            end
        end
    end

    assign hit   = |match;
    assign evict = !hit && (used >= num_ways);

    // Select the range that shifts toward the least recent end
    always_comb
    begin
        if (hit)
        begin
            shift_lo = CNT_W'(hit_idx);
            last     = used - CNT_W'(1);
        end
        else if (evict)
        begin
            shift_lo = '0;
            last     = num_ways - CNT_W'(1);
        end
        else
        begin
            shift_lo = used;
            last     = used;
        end
    end

    assign up_tags = row_tags >> lscs_pkg::ADDR_W;

    // Shift down, then place the tag at the most recent end
    always_comb
    begin
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            if (CNT_W'(p) == last)
            begin
                new_tags[p] = tag;
            end
            else if ((CNT_W'(p) >= shift_lo) && (CNT_W'(p) < last))
            begin
                new_tags[p] = up_tags[p];
            end
            else
            begin
                new_tags[p] = row_tags[p];
            end
        end
    end

    assign new_fill   = last + CNT_W'(1);
    assign stat.hit   = hit;
    assign stat.evict = evict;

endmodule

// File: rtl/lru_set_associative_cache_sim.sv
// An item is held while its row is read; the lookup state then puts its result in the output register.
// A new item waits until the last is written back; the row read and its write-back share the row memory.
// A full result waits in the output register; a stalled output holds the lookup stage.
// Reset: asynchronous, active low; clears the totals and all row-valid flags and loads the default config at once,
// so every set reads as empty right after reset with no clearing pass.
// Top level of the tag-only set-associative cache model with LRU replacement.
module lru_set_associative_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    lscs_req_if.sink        req,
    lscs_rsp_if.source      rsp,
    lscs_cfg_if.sink        cfg
);

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int TAGS_W = MAX_WAYS * lscs_pkg::ADDR_W;
    localparam int ROW_W  = TAGS_W + CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [lscs_pkg::SET_BITS_W-1:0]     set_bits_reg;
    logic [lscs_pkg::WAYS_W-1:0]         ways_reg;
    logic [lscs_pkg::BLOCK_BITS_W-1:0]   block_bits_reg;

    logic [SET_W-1:0]                    set_reg;
    logic [lscs_pkg::ADDR_W-1:0]         tag_reg;
    logic                                modify_reg;

    logic [lscs_pkg::TOT_W-1:0]          hit_tot_reg, hit_tot_next;
    logic [lscs_pkg::TOT_W-1:0]          miss_tot_reg, miss_tot_next;
    logic [lscs_pkg::TOT_W-1:0]          evict_tot_reg, evict_tot_next;

    logic                                out_valid_reg;
    logic                                out_hit_reg;
    logic                                out_evict_reg;
    logic                                out_modify_reg;

    logic                                accept;
    logic                                finish;
    logic [lscs_pkg::SET_BITS_W-1:0]     eff_sb;
    logic [lscs_pkg::WAYS_W:0]           ways_clip;
    logic [CNT_W-1:0]                    num_ways;
    logic [lscs_pkg::ADDR_W-1:0]         addr_shr;
    logic [lscs_pkg::BLOCK_BITS_W:0]     tag_shamt;
    logic [SET_W-1:0]                    set_idx;
    logic [lscs_pkg::ADDR_W-1:0]         tag_in;

    logic [ROW_W-1:0]                    rd_row;
    logic                                rd_ok;
    logic [ROW_W-1:0]                    wr_row;
    logic [MAX_WAYS-1:0][lscs_pkg::ADDR_W-1:0] new_tags;
    logic [CNT_W-1:0]                    new_fill;
    lscs_pkg::lkup_stat_t                stat;

    // Configuration registers; writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= lscs_pkg::WAYS_W'(1);
            block_bits_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lscs_pkg::REG_SET_BITS:   set_bits_reg   <= cfg.data[lscs_pkg::SET_BITS_W-1:0];
                lscs_pkg::REG_WAYS:       ways_reg       <= cfg.data[lscs_pkg::WAYS_W-1:0];
                lscs_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // Clamp the configuration to what the hardware holds
    assign eff_sb = (set_bits_reg > lscs_pkg::SET_BITS_W'(MAX_SET_BITS))
                  ? lscs_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_reg;

    always_comb
    begin
        ways_clip = {1'b0, ways_reg};
        if (ways_reg == '0)
        begin
            ways_clip = (lscs_pkg::WAYS_W + 1)'(1);
        end
        else if (ways_clip > (lscs_pkg::WAYS_W + 1)'(MAX_WAYS))
        begin
            ways_clip = (lscs_pkg::WAYS_W + 1)'(MAX_WAYS);
        end
    end

    assign num_ways = CNT_W'(ways_clip);

    // Split the address into set index and full-width tag
    assign addr_shr  = req.address >> block_bits_reg;
    assign tag_shamt = {1'b0, block_bits_reg} + (lscs_pkg::BLOCK_BITS_W + 1)'(eff_sb);
    assign tag_in    = tag_shamt[lscs_pkg::BLOCK_BITS_W]
                     ? '0 : (req.address >> tag_shamt[lscs_pkg::BLOCK_BITS_W-1:0]);
    assign set_idx   = addr_shr[SET_W-1:0] & ~({SET_W{1'b1}} << eff_sb);

    // Handshake and sequencing
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign finish    = (state_reg == ST_LOOK) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the item while its row is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
            modify_reg <= (req.operation == lscs_pkg::OP_MODIFY);
        end
    end

    // Row memory
    lscs_mem #(
        .ADDR_BITS (SET_W),
        .ROW_W     (ROW_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (set_idx),
        .rd_data (rd_row),
        .rd_ok   (rd_ok),
        .wr_en   (finish),
        .wr_addr (set_reg),
        .wr_data (wr_row)
    );

    // Compare and reorder the set
    lscs_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .row_tags (rd_row[TAGS_W-1:0]),
        .row_fill (rd_row[ROW_W-1:TAGS_W]),
        .row_ok   (rd_ok),
        .tag      (tag_reg),
        .num_ways (num_ways),
        .new_tags (new_tags),
        .new_fill (new_fill),
        .stat     (stat)
    );

    assign wr_row = {new_fill, new_tags};

    // Advance the saturating totals
    assign hit_tot_next   = lscs_pkg::sat_inc(lscs_pkg::sat_inc(hit_tot_reg, stat.hit), modify_reg);
    assign miss_tot_next  = lscs_pkg::sat_inc(miss_tot_reg, !stat.hit);
    assign evict_tot_next = lscs_pkg::sat_inc(evict_tot_reg, stat.evict);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            evict_tot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                hit_tot_reg   <= hit_tot_next;
                miss_tot_reg  <= miss_tot_next;
                evict_tot_reg <= evict_tot_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result flags
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_hit_reg    <= stat.hit;
            out_evict_reg  <= stat.evict;
            out_modify_reg <= modify_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.was_hit          = out_hit_reg;
    assign rsp.was_evicted      = out_evict_reg;
    assign rsp.modify_hit       = out_modify_reg;
    assign rsp.hits_so_far      = hit_tot_reg;
    assign rsp.misses_so_far    = miss_tot_reg;
    assign rsp.evictions_so_far = evict_tot_reg;

endmodule

// File: rtl/lscs_chk.sv
// Port-level checker for the cache model block, bound to the top level.
module lscs_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         was_hit,
    input logic                         was_evicted,
    input logic [lscs_pkg::TOT_W-1:0]   hits_so_far,
    input logic [lscs_pkg::TOT_W-1:0]   misses_so_far,
    input logic [lscs_pkg::TOT_W-1:0]   evictions_so_far
);

    // Hold a pending result until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    // Take no second item in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while the previous one is in lookup");

    // Hit and eviction exclude each other
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(was_hit && was_evicted))
        else $error("result flags both hit and eviction");

    // Evictions never outnumber misses, and a hit shows a nonzero hit total
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (evictions_so_far <= misses_so_far) &&
                      (!was_hit || (hits_so_far != '0)))
        else $error("running totals inconsistent with the result");

endmodule

bind lru_set_associative_cache_sim lscs_chk u_lscs_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .was_hit          (rsp.was_hit),
    .was_evicted      (rsp.was_evicted),
    .hits_so_far      (rsp.hits_so_far),
    .misses_so_far    (rsp.misses_so_far),
    .evictions_so_far (rsp.evictions_so_far)
);
